>>> hdl/glyph_blit_4bpp_top_defines.svh
// ----------------------------------------------------------------------------
// glyph blitter assertion macros
// shared concurrent check wrappers for the glyph blitter rtl
// ----------------------------------------------------------------------------
`ifndef GLYPH_BLIT_4BPP_TOP_DEFINES_SVH
`define GLYPH_BLIT_4BPP_TOP_DEFINES_SVH

// property sampled on the rising clock, quiet while reset is high
`define GB4_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define GB4_ASSERT_NEXT(label, ante, cons, msg) \
   `GB4_ASSERT_CLK(label, ante |=> cons, msg)

`endif

>>> hdl/gb4_pkg.sv
// ----------------------------------------------------------------------------
// gb4_pkg
// types, codes and pixel helpers shared by the glyph blitter modules
// ----------------------------------------------------------------------------
`default_nettype none

package gb4_pkg;

   // fonts the block knows about
   localparam int FONT_COUNT = 3;

   // one pixel nibble and the top bit of a font word
   localparam logic [31:0] NIBBLE_MASK = 32'h0000000f;
   localparam logic [4:0]  BIT_TOP     = 5'd31;

   // pixel offset y * width + x and its word part
   localparam int OFF_W    = 18;
   localparam int PIXW_W   = OFF_W - 3;
   localparam int BITPOS_W = 14;

   // config port
   localparam int CSR_W     = 10;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FB_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT0_BASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT1_BASE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT2_BASE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_PRESENT = 3'd4;

   // command codes
   localparam logic [2:0] CMD_LOAD_FONT   = 3'd0;
   localparam logic [2:0] CMD_DRAW_CHAR   = 3'd1;
   localparam logic [2:0] CMD_PLOT        = 3'd2;
   localparam logic [2:0] CMD_WRITE_FRAME = 3'd3;
   localparam logic [2:0] CMD_READ_FRAME  = 3'd4;

   // draw modes
   localparam logic [2:0] MODE_OR  = 3'd0;
   localparam logic [2:0] MODE_ON  = 3'd1;
   localparam logic [2:0] MODE_AND = 3'd2;
   localparam logic [2:0] MODE_REV = 3'd3;
   localparam logic [2:0] MODE_XOR = 3'd4;

   // font select codes
   localparam logic [1:0] FONT_3X5 = 2'd0;
   localparam logic [1:0] FONT_5X7 = 2'd1;
   localparam logic [1:0] FONT_5X5 = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FONT = 2'd1;
   localparam logic [1:0] STATUS_CLIP    = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [9:0]  word_index;
      logic [31:0] word_data;
      logic [7:0]  char_code;
      logic [7:0]  pos_x;
      logic [6:0]  pos_y;
      logic [1:0]  font_sel;
      logic [2:0]  draw_mode;
      logic        pixel_value;
      logic        add_gap;
   } gb4_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } gb4_rsp_type;

   // pixel location from the address unit
   typedef struct packed {
      logic [PIXW_W-1:0] word;
      logic [2:0]        nib;
      logic              clip;
   } gb4_pix_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_SET,
      OP_INV,
      OP_CLR
   } gb4_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SETUP,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_READ_WAIT
   } gb4_state_type;

   // glyph width per font
   function automatic logic [2:0] glyph_w(input logic [1:0] sel);
      logic [2:0] w;
      unique case (sel)
         FONT_3X5: w = 3'd3;
         FONT_5X7: w = 3'd5;
         default:  w = 3'd5;
      endcase
      return w;
   endfunction

   // glyph height per font
   function automatic logic [2:0] glyph_h(input logic [1:0] sel);
      logic [2:0] h;
      unique case (sel)
         FONT_3X5: h = 3'd5;
         FONT_5X7: h = 3'd7;
         default:  h = 3'd5;
      endcase
      return h;
   endfunction

   // bits per glyph
   function automatic logic [5:0] glyph_area(input logic [1:0] sel);
      logic [5:0] a;
      unique case (sel)
         FONT_3X5: a = 6'd15;
         FONT_5X7: a = 6'd35;
         default:  a = 6'd25;
      endcase
      return a;
   endfunction

   // nibble operation for one source bit
   function automatic gb4_op_type pix_op(input logic [2:0] mode, input logic v);
      gb4_op_type op;
      unique case (mode)
         MODE_OR:  op = v ? OP_SET : OP_NONE;
         MODE_ON:  op = v ? OP_SET : OP_CLR;
         MODE_AND: op = v ? OP_CLR : OP_NONE;
         MODE_REV: op = v ? OP_CLR : OP_SET;
         MODE_XOR: op = v ? OP_INV : OP_NONE;
         default:  op = OP_NONE;
      endcase
      return op;
   endfunction

   // apply a nibble operation to a frame word
   function automatic logic [31:0] apply_op(input logic [31:0] word, input logic [2:0] nib,
                                            input gb4_op_type op);
      logic [31:0] mask;
      logic [31:0] res;
      mask = NIBBLE_MASK << {nib, 2'b00};
      unique case (op)
         OP_SET:  res = word | mask;
         OP_INV:  res = word ^ mask;
         OP_CLR:  res = word & ~mask;
         default: res = word;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hdl/gb4_ram.sv
// ----------------------------------------------------------------------------
// gb4_ram
// word memory with one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gb4_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [31:0]       wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [31:0]       rdata
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/gb4_pix_unit.sv
// ----------------------------------------------------------------------------
// gb4_pix_unit
// shared pixel address unit: offset y * width + x, word, nibble and clip
// ----------------------------------------------------------------------------
`default_nettype none

module gb4_pix_unit #(
   parameter int FRAME_WORDS = 1024
) (
   input  logic [8:0]          px,
   input  logic [7:0]          py,
   input  logic [8:0]          fb_width,
   output gb4_pkg::gb4_pix_type pix
);

   import gb4_pkg::*;

   logic [OFF_W-1:0] off;

   // one multiply-add per pixel
   assign off = {{(OFF_W-8){1'b0}}, py} * {{(OFF_W-9){1'b0}}, fb_width}
              + {{(OFF_W-9){1'b0}}, px};

   // split into word and nibble, flag words past the store
   assign pix.word = off[OFF_W-1:3];
   assign pix.nib  = off[2:0];
   assign pix.clip = (32'(off[OFF_W-1:3]) >= FRAME_WORDS);

endmodule

`default_nettype wire

>>> hdl/glyph_blit_4bpp_top.sv
// ----------------------------------------------------------------------------
// glyph_blit_4bpp_top
// glyph blitter into a 4-bit-per-pixel frame store with a font store
// ----------------------------------------------------------------------------
// latency, accept edge to strobe, follows the states: load, write and other commands
// answer from decode, an in-range frame read via the read wait, a plot via a pixel
// read and write, a draw via setup and a read and a write per pixel (w*h, plus h with
// the gap column); each pixel is a read-modify-write of a frame word through the
// shared address unit; a new command is taken in the cycle the strobe is shown;
// results cannot stall; after reset the frame store is cleared one word a cycle
`default_nettype none

`include "glyph_blit_4bpp_top_defines.svh"

module glyph_blit_4bpp_top #(
   parameter int FRAME_WORDS = 1024,
   parameter int FONT_WORDS  = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  gb4_pkg::gb4_req_type               req_data,
   output logic                               rsp_valid,
   output gb4_pkg::gb4_rsp_type               rsp_data,
   input  logic                               csr_we,
   input  logic [gb4_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gb4_pkg::CSR_W-1:0]          csr_wdata
);

   import gb4_pkg::*;

   localparam int FRAME_AW = $clog2(FRAME_WORDS);
   localparam int FONT_AW  = $clog2(FONT_WORDS);

   // control and payload registers
   gb4_state_type     state_ff, state_in;
   gb4_req_type       req_ff, req_in;
   logic [FRAME_AW-1:0] clr_ff, clr_in;
   logic [2:0]        col_ff, col_in;
   logic [2:0]        row_ff, row_in;
   logic              gap_ph_ff, gap_ph_in;
   logic [BITPOS_W-1:0] bitpos_ff, bitpos_in;
   logic              clip_ff, clip_in;
   gb4_pix_type       pix_ff, pix_in;
   logic              font_ok_ff, font_ok_in;
   logic [4:0]        bitsel_ff, bitsel_in;
   gb4_rsp_type       rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // config registers
   logic [8:0]        fb_width_ff;
   logic [9:0]        font0_base_ff;
   logic [9:0]        font1_base_ff;
   logic [9:0]        font2_base_ff;
   logic [2:0]        present_ff;

   // memory ports
   logic                frame_we;
   logic [FRAME_AW-1:0] frame_waddr;
   logic [31:0]         frame_wdata;
   logic [FRAME_AW-1:0] frame_raddr;
   logic [31:0]         frame_rdata;
   logic                font_we;
   logic [FONT_AW-1:0]  font_raddr;
   logic [31:0]         font_rdata;

   // datapath signals
   logic [2:0]   sel_w;
   logic [2:0]   sel_h;
   logic [5:0]   sel_area;
   logic [9:0]   sel_base;
   logic [3:0]   present_ext;
   logic         font_missing;
   logic [8:0]   px;
   logic [7:0]   py;
   gb4_pix_type  pix;
   logic [10:0]  font_word;
   logic         font_word_ok;
   logic         idx_font_ok;
   logic         idx_frame_ok;
   logic         src_bit;
   logic [31:0]  new_word;
   logic         is_plot;
   logic         last_pix;
   logic         clip_now;

   // config writes, taken at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff   <= 9'd128;
         font0_base_ff <= '0;
         font1_base_ff <= '0;
         font2_base_ff <= '0;
         present_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FB_WIDTH:     fb_width_ff   <= csr_wdata[8:0];
            CSR_FONT0_BASE:   font0_base_ff <= csr_wdata[9:0];
            CSR_FONT1_BASE:   font1_base_ff <= csr_wdata[9:0];
            CSR_FONT2_BASE:   font2_base_ff <= csr_wdata[9:0];
            CSR_FONT_PRESENT: present_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // font geometry and base
   assign sel_w    = glyph_w(req_ff.font_sel);
   assign sel_h    = glyph_h(req_ff.font_sel);
   assign sel_area = glyph_area(req_ff.font_sel);

   always_comb begin
      unique case (req_ff.font_sel)
         FONT_3X5: sel_base = font0_base_ff;
         FONT_5X7: sel_base = font1_base_ff;
         FONT_5X5: sel_base = font2_base_ff;
         default:  sel_base = '0;
      endcase
   end

   // present bits widened so every select code has a bit
   assign present_ext  = {1'b0, present_ff};
   assign font_missing = (32'(req_ff.font_sel) >= FONT_COUNT) ||
                         !present_ext[req_ff.font_sel];

   // current pixel: glyph column or gap column
   assign is_plot = (req_ff.cmd == CMD_PLOT);
   assign px = {1'b0, req_ff.pos_x} + (gap_ph_ff ? {6'b0, sel_w} : {6'b0, col_ff});
   assign py = {1'b0, req_ff.pos_y} + {5'b0, row_ff};

   gb4_pix_unit #(
      .FRAME_WORDS(FRAME_WORDS)
   ) u_pix (
      .px       (px),
      .py       (py),
      .fb_width (fb_width_ff),
      .pix      (pix)
   );

   // font word holding the current glyph bit
   assign font_word    = {1'b0, sel_base} + {2'b0, bitpos_ff[BITPOS_W-1:5]};
   assign font_word_ok = (32'(font_word) < FONT_WORDS);

   // address range checks for word commands
   assign idx_font_ok  = (32'(req_ff.word_index) < FONT_WORDS);
   assign idx_frame_ok = (32'(req_ff.word_index) < FRAME_WORDS);

   // source bit and modified frame word
   always_comb begin
      if (is_plot) begin
         src_bit = req_ff.pixel_value;
      end else if (gap_ph_ff || !font_ok_ff) begin
         src_bit = 1'b0;
      end else begin
         src_bit = font_rdata[BIT_TOP - bitsel_ff];
      end
   end

   assign new_word = apply_op(frame_rdata, pix_ff.nib, pix_op(req_ff.draw_mode, src_bit));
   assign clip_now = clip_ff | pix_ff.clip;

   // end of the pixel walk
   always_comb begin
      if (is_plot) begin
         last_pix = 1'b1;
      end else if (gap_ph_ff) begin
         last_pix = (row_ff == sel_h - 3'd1);
      end else begin
         last_pix = (col_ff == sel_w - 3'd1) && (row_ff == sel_h - 3'd1) && !req_ff.add_gap;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == FRAME_AW'(FRAME_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (req_ff.cmd)
               CMD_DRAW_CHAR:  state_in = font_missing ? ST_IDLE : ST_SETUP;
               CMD_PLOT:       state_in = ST_PIX_RD;
               CMD_READ_FRAME: state_in = idx_frame_ok ? ST_READ_WAIT : ST_IDLE;
               default:        state_in = ST_IDLE;
            endcase
         end
         ST_SETUP:     state_in = ST_PIX_RD;
         ST_PIX_RD:    state_in = ST_PIX_WR;
         ST_PIX_WR:    state_in = last_pix ? ST_IDLE : ST_PIX_RD;
         ST_READ_WAIT: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      req_in       = req_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      gap_ph_in    = gap_ph_ff;
      bitpos_in    = bitpos_ff;
      clip_in      = clip_ff;
      pix_in       = pix_ff;
      font_ok_in   = font_ok_ff;
      bitsel_in    = bitsel_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      frame_we     = 1'b0;
      frame_waddr  = FRAME_AW'(req_ff.word_index);
      frame_wdata  = req_ff.word_data;
      frame_raddr  = FRAME_AW'(req_ff.word_index);
      font_we      = 1'b0;
      font_raddr   = FONT_AW'(font_word);

      unique case (state_ff)
         // clearing pass over the frame store
         ST_CLEAR: begin
            frame_we    = 1'b1;
            frame_waddr = clr_ff;
            frame_wdata = '0;
            clr_in      = clr_ff + FRAME_AW'(1);
         end
         ST_IDLE: begin
            if (start) req_in = req_data;
         end
         // word commands and fontless draws finish here, in-range frame reads go on to the read wait, pixel walks start
         ST_DECODE: begin
            col_in    = '0;
            row_in    = '0;
            gap_ph_in = 1'b0;
            clip_in   = 1'b0;
            unique case (req_ff.cmd)
               CMD_LOAD_FONT: begin
                  font_we          = idx_font_ok;
                  rsp_valid_in     = 1'b1;
                  rsp_in.read_data = '0;
                  rsp_in.status    = idx_font_ok ? STATUS_OK : STATUS_CLIP;
               end
               CMD_DRAW_CHAR: begin
                  if (font_missing) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.read_data = '0;
                     rsp_in.status    = STATUS_NO_FONT;
                  end
               end
               CMD_PLOT: ;
               CMD_WRITE_FRAME: begin
                  frame_we         = idx_frame_ok;
                  rsp_valid_in     = 1'b1;
                  rsp_in.read_data = '0;
                  rsp_in.status    = idx_frame_ok ? STATUS_OK : STATUS_CLIP;
               end
               CMD_READ_FRAME: begin
                  if (!idx_frame_ok) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.read_data = '0;
                     rsp_in.status    = STATUS_CLIP;
                  end
               end
               default: begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.read_data = '0;
                  rsp_in.status    = STATUS_OK;
               end
            endcase
         end
         // first glyph bit position
         ST_SETUP: begin
            bitpos_in = {6'b0, req_ff.char_code} * {8'b0, sel_area};
         end
         // read the frame word and the font word
         ST_PIX_RD: begin
            frame_raddr = FRAME_AW'(pix.word);
            pix_in      = pix;
            font_ok_in  = font_word_ok;
            bitsel_in   = bitpos_ff[4:0];
         end
         // write back the modified word and step the walk
         ST_PIX_WR: begin
            frame_we    = !pix_ff.clip;
            frame_waddr = FRAME_AW'(pix_ff.word);
            frame_wdata = new_word;
            clip_in     = clip_now;
            if (!is_plot) begin
               if (gap_ph_ff) begin
                  row_in = row_ff + 3'd1;
               end else begin
                  bitpos_in = bitpos_ff + BITPOS_W'(1);
                  if (col_ff == sel_w - 3'd1) begin
                     col_in = '0;
                     if (row_ff == sel_h - 3'd1) begin
                        row_in    = '0;
                        gap_ph_in = 1'b1;
                     end else begin
                        row_in = row_ff + 3'd1;
                     end
                  end else begin
                     col_in = col_ff + 3'd1;
                  end
               end
            end
            if (last_pix) begin
               rsp_valid_in     = 1'b1;
               rsp_in.read_data = '0;
               rsp_in.status    = clip_now ? STATUS_CLIP : STATUS_OK;
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in     = 1'b1;
            rsp_in.read_data = frame_rdata;
            rsp_in.status    = STATUS_OK;
         end
         default: ;
      endcase
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      gap_ph_ff  <= gap_ph_in;
      bitpos_ff  <= bitpos_in;
      clip_ff    <= clip_in;
      pix_ff     <= pix_in;
      font_ok_ff <= font_ok_in;
      bitsel_ff  <= bitsel_in;
      rsp_ff     <= rsp_in;
   end

   // frame store
   gb4_ram #(
      .DEPTH(FRAME_WORDS)
   ) u_frame (
      .clock (clock),
      .we    (frame_we),
      .waddr (frame_waddr),
      .wdata (frame_wdata),
      .raddr (frame_raddr),
      .rdata (frame_rdata)
   );

   // font store
   gb4_ram #(
      .DEPTH(FONT_WORDS)
   ) u_font (
      .clock (clock),
      .we    (font_we),
      .waddr (FONT_AW'(req_ff.word_index)),
      .wdata (req_ff.word_data),
      .raddr (font_raddr),
      .rdata (font_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `GB4_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted word did not raise busy")
   `GB4_ASSERT_NEXT(a_rsp_one_cycle, rsp_valid, !rsp_valid, "response strobe held two cycles")
   `GB4_ASSERT_CLK(a_rsp_after_work, rsp_valid |-> ($past(state_ff) != ST_IDLE), "response without work")
   `GB4_ASSERT_CLK(a_no_clipped_write, (state_ff == ST_PIX_WR) && frame_we |-> !pix_ff.clip, "write to clipped pixel")

endmodule

`default_nettype wire
